// ----- src/dss_pkg.sv -----
// Shared constants, register indexes and the sine table builder for the sine source.
package dss_pkg;

   localparam int PhaseBits    = 32;
   localparam int SineDepth    = 1024;
   localparam int SineAddrBits = $clog2(SineDepth);

   localparam int CsrAddrBits = 2;
   localparam int CsrDataBits = 32;

   localparam logic [CsrAddrBits-1:0] RegPhaseStep   = 2'd0;
   localparam logic [CsrAddrBits-1:0] RegAmplitudeMv = 2'd1;
   localparam logic [CsrAddrBits-1:0] RegNoiseMv     = 2'd2;
   localparam logic [CsrAddrBits-1:0] RegBurstEnable = 2'd3;

   localparam logic [31:0] PhaseStepReset   = 32'd16106127;
   localparam logic [9:0]  AmplitudeMvReset = 10'd50;
   localparam logic [6:0]  NoiseMvReset     = 7'd1;

   localparam int LegBits = 23;
   localparam logic signed [26:0] BiasUv = 27'sd2500000;
   localparam logic signed [26:0] FullUv = 27'sd5000000;

   // Polynomial coefficients of the quarter-wave sine, all in Q30.
   localparam logic [63:0] CoefA1  = 64'd1686629713;
   localparam logic [63:0] CoefA3  = 64'd693598668;
   localparam logic [63:0] CoefA5  = 64'd85569307;
   localparam logic [63:0] CoefA7  = 64'd5026995;
   localparam logic [63:0] CoefA9  = 64'd172272;
   localparam logic [63:0] Q30One  = 64'd1073741824;

   typedef logic signed [15:0] sine_rom_type [SineDepth];

   // Builds the Q1.15 sine table at elaboration time.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  u;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  p;
      logic [63:0]  s;
      logic [1:0]   quad;
      for (int i = 0; i < SineDepth; i++) begin
         u    = (64'(i) << 32) / 64'(SineDepth);
         quad = u[31:30];
         x    = {34'd0, u[29:0]};
         if (quad[0]) begin
            x = Q30One - x;
         end
         x2 = (x * x) >> 30;
         p  = CoefA7 - ((x2 * CoefA9) >> 30);
         p  = CoefA5 - ((x2 * p) >> 30);
         p  = CoefA3 - ((x2 * p) >> 30);
         p  = CoefA1 - ((x2 * p) >> 30);
         s  = (x * p) >> 30;
         s  = (s + 64'd16384) >> 15;
         if (s > 64'd32767) begin
            s = 64'd32767;
         end
         rom[i] = quad[1] ? -16'(s) : 16'(s);
      end
      return rom;
   endfunction

endpackage

// ----- src/dss_sine_rom.sv -----
// Synchronous sine table memory with a registered read port.
module dss_sine_rom
   import dss_pkg::*;
(
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [SineAddrBits-1:0] rd_addr,
   output logic signed [15:0]      rd_data
);

   localparam sine_rom_type SineRom = build_sine_rom();

   logic signed [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SineRom[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/differential_sine_source_unit.sv -----
// Top level of the differential sine source: phase accumulator, table read and leg math.
//
// Every item on the req_ stream is one sample tick. It carries a Q1.15 noise sample and
// produces exactly one item on the rsp_ stream with the two leg voltages in microvolts and
// a clip flag. On each accepted item the phase accumulator advances by phase_step and the
// new phase addresses the sine table memory, whose read data is registered.
// The path has three register stages (table read, scaling multiplies, bias add and clamp
// into the output register); an accepted item passes through them in that order before
// rsp_tvalid rises and the result can be taken.
// One item can be accepted in every cycle while no stall holds the stages; the rate is one
// item per cycle, set by the single table read port and the phase add that feeds it.
// Each stage moves forward whenever the stage ahead of it is empty or moving, so empty
// stages keep filling while a finished result waits for rsp_tready; req_tready drops only
// when all three stages hold items and the receiver stalls.
// The csr_ port writes the four configuration registers; writes take effect at once and
// are meant to happen while no item is in flight.
// Synchronous reset clears the accumulator and the stage valid flags and restores the
// register defaults (15 Hz step, 50 mV amplitude, 1 mV noise, burst off).
module differential_sine_source_unit
   import dss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,   // [15:0] noise_sample
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [47:0]            rsp_tdata,   // [22:0] pos_leg_uv, [45:23] neg_leg_uv, pad
   output logic                   rsp_tuser,   // [0] clipped
   input  logic                   csr_we,
   input  logic [CsrAddrBits-1:0] csr_addr,
   input  logic [CsrDataBits-1:0] csr_wdata
);

   // Configuration registers.
   logic [31:0] phase_step_ff;
   logic [9:0]  amplitude_mv_ff;
   logic [6:0]  noise_mv_ff;
   logic        burst_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= PhaseStepReset;
         amplitude_mv_ff <= AmplitudeMvReset;
         noise_mv_ff     <= NoiseMvReset;
         burst_enable_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            RegPhaseStep:   phase_step_ff   <= csr_wdata[31:0];
            RegAmplitudeMv: amplitude_mv_ff <= csr_wdata[9:0];
            RegNoiseMv:     noise_mv_ff     <= csr_wdata[6:0];
            RegBurstEnable: burst_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Stage flow control: a stage advances when the one ahead is empty or advancing.
   logic s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic s1_valid_in, s2_valid_in, out_valid_in;
   logic s1_en, s2_en, out_en;
   logic req_fire;

   assign out_en     = !out_valid_ff || rsp_tready;
   assign s2_en      = !s2_valid_ff || out_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_tready = s1_en;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = s1_en ? req_fire : s1_valid_ff;
   assign s2_valid_in  = s2_en ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_en ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Phase accumulator; the updated phase picks the table entry.
   logic [PhaseBits-1:0] phase_ff;
   logic [PhaseBits-1:0] phase_in;

   assign phase_in = phase_ff + PhaseBits'(phase_step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
      end
   end

   logic signed [15:0] sine_s1;

   dss_sine_rom u_sine_rom (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (phase_in[PhaseBits-1 -: SineAddrBits]),
      .rd_data (sine_s1)
   );

   // Stage 1: noise sample and scale factors in microvolts, alongside the table read.
   logic signed [15:0] noise_s1_ff, noise_s1_in;
   logic [23:0]        amp_uv_s1_ff, amp_uv_s1_in;
   logic [16:0]        noise_uv_s1_ff, noise_uv_s1_in;
   logic [13:0]        amp_gain;

   assign amp_gain       = burst_enable_ff ? 14'(amplitude_mv_ff) * 14'd10
                                           : 14'(amplitude_mv_ff);
   assign noise_s1_in    = req_tdata;
   assign amp_uv_s1_in   = 24'(amp_gain) * 24'd1000;
   assign noise_uv_s1_in = 17'(noise_mv_ff) * 17'd1000;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         noise_s1_ff    <= noise_s1_in;
         amp_uv_s1_ff   <= amp_uv_s1_in;
         noise_uv_s1_ff <= noise_uv_s1_in;
      end
   end

   // Stage 2: sign-magnitude multiplies, rounded half away from zero.
   logic        sine_neg, noise_neg;
   logic [15:0] sine_mag, noise_mag;
   logic [39:0] sig_prod;
   logic [33:0] noise_prod;
   logic [23:0] sig_mag;
   logic [16:0] noise_uv_mag;
   logic signed [24:0] sig_s2_ff, sig_s2_in;
   logic signed [17:0] noise_s2_ff, noise_s2_in;

   assign sine_neg     = sine_s1[15];
   assign noise_neg    = noise_s1_ff[15];
   assign sine_mag     = sine_neg ? 16'(-sine_s1) : 16'(sine_s1);
   assign noise_mag    = noise_neg ? 16'(-noise_s1_ff) : 16'(noise_s1_ff);
   assign sig_prod     = 40'(amp_uv_s1_ff) * 40'(sine_mag) + 40'd16384;
   assign noise_prod   = 34'(noise_uv_s1_ff) * 34'(noise_mag) + 34'd16384;
   assign sig_mag      = sig_prod[38:15];
   assign noise_uv_mag = noise_prod[31:15];
   assign sig_s2_in    = sine_neg ? -$signed({1'b0, sig_mag}) : $signed({1'b0, sig_mag});
   assign noise_s2_in  = noise_neg ? -$signed({1'b0, noise_uv_mag})
                                   : $signed({1'b0, noise_uv_mag});

   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         sig_s2_ff   <= sig_s2_in;
         noise_s2_ff <= noise_s2_in;
      end
   end

   // Stage 3: bias, common noise and saturation of each leg into the output register.
   logic signed [26:0] pos_sum, neg_sum;
   logic [LegBits-1:0] pos_leg_ff, pos_leg_in, neg_leg_ff, neg_leg_in;
   logic               clipped_ff, clipped_in;
   logic               pos_clip, neg_clip;

   assign pos_sum = BiasUv + 27'(sig_s2_ff) + 27'(noise_s2_ff);
   assign neg_sum = BiasUv - 27'(sig_s2_ff) + 27'(noise_s2_ff);

   always_comb begin
      pos_clip = 1'b1;
      neg_clip = 1'b1;
      if (pos_sum < 0) begin
         pos_leg_in = '0;
      end else if (pos_sum > FullUv) begin
         pos_leg_in = LegBits'(FullUv);
      end else begin
         pos_leg_in = LegBits'(pos_sum);
         pos_clip   = 1'b0;
      end
      if (neg_sum < 0) begin
         neg_leg_in = '0;
      end else if (neg_sum > FullUv) begin
         neg_leg_in = LegBits'(FullUv);
      end else begin
         neg_leg_in = LegBits'(neg_sum);
         neg_clip   = 1'b0;
      end
      clipped_in = pos_clip || neg_clip;
   end

   always_ff @(posedge clock) begin
      if (out_en && s2_valid_ff) begin
         pos_leg_ff <= pos_leg_in;
         neg_leg_ff <= neg_leg_in;
         clipped_ff <= clipped_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, neg_leg_ff, pos_leg_ff};
   assign rsp_tuser  = clipped_ff;

   // The accumulator moves by exactly one step per accepted item.
   a_phase_advance: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> phase_ff == $past(phase_in))
      else $error("phase accumulator did not advance by the step");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(phase_ff))
      else $error("phase accumulator moved without an accepted item");

   // Saturation keeps both legs inside the supply range.
   a_leg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pos_leg_ff <= LegBits'(FullUv)) && (neg_leg_ff <= LegBits'(FullUv)))
      else $error("leg voltage outside the supply range");

   // A stalled output never lets the stage behind it be overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready && s2_valid_ff |=> s2_valid_ff)
      else $error("pending item dropped while the output stalled");

endmodule
